// ===== sv/tlpt_pkg.sv =====
// shared constants and types of the two-level page table manager
`default_nettype none

package tlpt_pkg;

   localparam int NUM_TABLES_DEF = 8;
   localparam int DIR_SLOTS      = 1024;
   localparam int TABLE_SLOTS    = 1024;
   localparam int IDX_W          = 10;
   localparam int DIR_SHIFT      = 22;
   localparam int PAGE_SHIFT     = 12;
   localparam int FLAG_W         = 12;
   localparam int FRAME_W        = 32 - PAGE_SHIFT;
   localparam int FLAG_USER_BIT  = 2;

   typedef enum logic [1:0] {
      FUNC_MAP    = 2'd0,
      FUNC_UNMAP  = 2'd1,
      FUNC_LOOKUP = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      ST_DONE       = 2'd0,
      ST_NO_TABLE   = 2'd1,
      ST_POOL_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_DIR,
      S_TBL
   } state_type;

endpackage

`default_nettype wire

// ===== sv/tlpt_if.sv =====
// request and response channel interfaces of the page table manager
`default_nettype none

interface tlpt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [31:0] virt_addr;
   logic [31:0] phys_addr;
   logic [11:0] page_flags;

   modport source (output valid, output func, output virt_addr, output phys_addr,
                   output page_flags, input ready);
   modport sink (input valid, input func, input virt_addr, input phys_addr,
                 input page_flags, output ready);
endinterface

interface tlpt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] frame_result;
   logic        release_frame;
   logic        tlb_flush;

   modport source (output valid, output status, output frame_result,
                   output release_frame, output tlb_flush, input ready);
   modport sink (input valid, input status, input frame_result,
                 input release_frame, input tlb_flush, output ready);
endinterface

`default_nettype wire

// ===== sv/tlpt_ram.sv =====
// single-port-write, single-port-read synchronous ram with registered read data
`default_nettype none

module tlpt_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/two_level_page_table_manager.sv =====
// top level of the two-level page table manager
// map, function code 3 and absent-slot requests finish after the directory read; unmap and
//   lookup of a present slot also need a table read (directory read, then table read)
// requests are handled one at a time: req_if.ready is high only while idle
// reset: synchronous; afterwards a clearing pass over the NUM_TABLES*1024 table ram words
//   zeroes both rams while req_if.ready stays low
`default_nettype none

module two_level_page_table_manager #(
   parameter int NUM_TABLES = tlpt_pkg::NUM_TABLES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   tlpt_req_if.sink   req_if,
   tlpt_rsp_if.source rsp_if
);

   localparam int TBL_W     = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
   localparam int CNT_W     = $clog2(NUM_TABLES + 1);
   localparam int CLEAR_LEN = NUM_TABLES * tlpt_pkg::TABLE_SLOTS;
   localparam int ADDR_W    = $clog2(CLEAR_LEN);
   localparam int DIR_W     = TBL_W + 2;
   localparam int IDX_W     = tlpt_pkg::IDX_W;
   localparam int FRAME_W   = tlpt_pkg::FRAME_W;
   localparam int FLAG_W    = tlpt_pkg::FLAG_W;

   // control state
   tlpt_pkg::state_type state_ff, state_in;
   logic [ADDR_W-1:0]   clr_ff, clr_in;
   logic [CNT_W-1:0]    tbl_cnt_ff, tbl_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // request held while it is worked on
   logic [1:0]          func_ff;
   logic [IDX_W-1:0]    di_ff;
   logic [IDX_W-1:0]    ti_ff;
   logic [FRAME_W-1:0]  pa_frame_ff;
   logic [FLAG_W-1:0]   flags_ff;
   logic [ADDR_W-1:0]   entry_addr_ff;

   // result register
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [FRAME_W-1:0]  rsp_frame_ff, rsp_frame_in;
   logic                rsp_release_ff, rsp_release_in;
   logic                rsp_flush_ff, rsp_flush_in;

   // ram ports
   logic                dir_we, dir_re;
   logic [IDX_W-1:0]    dir_wa, dir_ra;
   logic [DIR_W-1:0]    dir_wd, dir_rd;
   logic                tbl_we, tbl_re;
   logic [ADDR_W-1:0]   tbl_wa, tbl_ra;
   logic [31:0]         tbl_wd, tbl_rd;

   // decode
   logic                req_ready;
   logic                req_beat;
   logic                out_free;
   logic                rsp_load;
   logic                cnt_inc;
   logic                clr_done;
   logic                clr_in_dir;
   logic                dir_present;
   logic                claim;
   logic                need_tbl_read;
   logic [TBL_W-1:0]    tbl_sel;
   logic [ADDR_W-1:0]   entry_addr;
   logic [FRAME_W-1:0]  rd_frame;

   tlpt_ram #(
      .WIDTH (DIR_W),
      .DEPTH (tlpt_pkg::DIR_SLOTS)
   ) u_dir_ram (
      .clock   (clock),
      .wr_en   (dir_we),
      .wr_addr (dir_wa),
      .wr_data (dir_wd),
      .rd_en   (dir_re),
      .rd_addr (dir_ra),
      .rd_data (dir_rd)
   );

   tlpt_ram #(
      .WIDTH  (32),
      .DEPTH  (CLEAR_LEN),
      .ADDR_W (ADDR_W)
   ) u_tbl_ram (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_wa),
      .wr_data (tbl_wd),
      .rd_en   (tbl_re),
      .rd_addr (tbl_ra),
      .rd_data (tbl_rd)
   );

   assign req_beat = req_if.valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // clearing pass covers the whole table ram, the directory is its first 1024 words
   assign clr_done   = (clr_ff == ADDR_W'(CLEAR_LEN - 1));
   assign clr_in_dir = ((clr_ff >> IDX_W) == '0);

   // directory word: present, user, table number
   assign dir_present = dir_rd[DIR_W-1];

   // tables are never given back, so the lowest free one is the claim count
   assign claim   = (func_ff == tlpt_pkg::FUNC_MAP) && !dir_present &&
                    (tbl_cnt_ff != CNT_W'(NUM_TABLES));
   assign tbl_sel = dir_present ? dir_rd[TBL_W-1:0] : TBL_W'(tbl_cnt_ff);

   assign entry_addr = (ADDR_W'(tbl_sel) << IDX_W) | ADDR_W'(ti_ff);

   assign need_tbl_read = dir_present &&
                          ((func_ff == tlpt_pkg::FUNC_UNMAP) ||
                           (func_ff == tlpt_pkg::FUNC_LOOKUP));

   // an entry never written reads as zero thanks to the clearing pass
   assign rd_frame = tbl_rd[31 -: FRAME_W];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tlpt_pkg::S_CLEAR: begin
            if (clr_done) begin
               state_in = tlpt_pkg::S_IDLE;
            end
         end
         tlpt_pkg::S_IDLE: begin
            if (req_beat) begin
               state_in = tlpt_pkg::S_DIR;
            end
         end
         tlpt_pkg::S_DIR: begin
            if (need_tbl_read) begin
               state_in = tlpt_pkg::S_TBL;
            end else if (out_free) begin
               state_in = tlpt_pkg::S_IDLE;
            end
         end
         tlpt_pkg::S_TBL: begin
            if (out_free) begin
               state_in = tlpt_pkg::S_IDLE;
            end
         end
         default: state_in = tlpt_pkg::S_CLEAR;
      endcase
   end

   // outputs, ram controls and result
   always_comb begin
      req_ready      = 1'b0;
      dir_we         = 1'b0;
      dir_wa         = di_ff;
      dir_wd         = {1'b1, flags_ff[tlpt_pkg::FLAG_USER_BIT], tbl_sel};
      dir_re         = 1'b0;
      dir_ra         = req_if.virt_addr[tlpt_pkg::DIR_SHIFT +: IDX_W];
      tbl_we         = 1'b0;
      tbl_wa         = entry_addr;
      tbl_wd         = {pa_frame_ff, flags_ff};
      tbl_re         = 1'b0;
      tbl_ra         = entry_addr;
      cnt_inc        = 1'b0;
      rsp_load       = 1'b0;
      rsp_status_in  = tlpt_pkg::ST_DONE;
      rsp_frame_in   = '0;
      rsp_release_in = 1'b0;
      rsp_flush_in   = 1'b0;
      case (state_ff)
         tlpt_pkg::S_CLEAR: begin
            dir_we = clr_in_dir;
            dir_wa = clr_ff[IDX_W-1:0];
            dir_wd = '0;
            tbl_we = 1'b1;
            tbl_wa = clr_ff;
            tbl_wd = '0;
         end
         tlpt_pkg::S_IDLE: begin
            req_ready = 1'b1;
            dir_re    = req_beat;
         end
         tlpt_pkg::S_DIR: begin
            if (need_tbl_read) begin
               tbl_re = 1'b1;
            end else if (out_free) begin
               rsp_load = 1'b1;
               case (func_ff)
                  tlpt_pkg::FUNC_MAP: begin
                     if (dir_present || claim) begin
                        tbl_we       = 1'b1;
                        dir_we       = claim;
                        cnt_inc      = claim;
                        rsp_flush_in = 1'b1;
                     end else begin
                        rsp_status_in = tlpt_pkg::ST_POOL_EMPTY;
                     end
                  end
                  tlpt_pkg::FUNC_UNMAP,
                  tlpt_pkg::FUNC_LOOKUP: begin
                     // only reached with an absent slot
                     rsp_status_in = tlpt_pkg::ST_NO_TABLE;
                  end
                  default: begin
                     // unused code: plain done, nothing touched
                     rsp_status_in = tlpt_pkg::ST_DONE;
                  end
               endcase
            end
         end
         tlpt_pkg::S_TBL: begin
            if (out_free) begin
               rsp_load     = 1'b1;
               rsp_frame_in = rd_frame;
               if (func_ff == tlpt_pkg::FUNC_UNMAP) begin
                  tbl_we         = 1'b1;
                  tbl_wa         = entry_addr_ff;
                  tbl_wd         = '0;
                  rsp_release_in = (rd_frame != '0);
                  rsp_flush_in   = 1'b1;
               end
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign clr_in       = clr_ff + ADDR_W'(1);
   assign tbl_cnt_in   = tbl_cnt_ff + CNT_W'(1);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_if.ready);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tlpt_pkg::S_CLEAR;
         clr_ff       <= '0;
         tbl_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == tlpt_pkg::S_CLEAR) begin
            clr_ff <= clr_in;
         end
         if (cnt_inc) begin
            tbl_cnt_ff <= tbl_cnt_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_beat) begin
         func_ff     <= req_if.func;
         di_ff       <= req_if.virt_addr[tlpt_pkg::DIR_SHIFT +: IDX_W];
         ti_ff       <= req_if.virt_addr[tlpt_pkg::PAGE_SHIFT +: IDX_W];
         pa_frame_ff <= req_if.phys_addr[tlpt_pkg::PAGE_SHIFT +: FRAME_W];
         flags_ff    <= req_if.page_flags;
      end
      if (state_ff == tlpt_pkg::S_DIR) begin
         entry_addr_ff <= entry_addr;
      end
      if (rsp_load) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_frame_ff   <= rsp_frame_in;
         rsp_release_ff <= rsp_release_in;
         rsp_flush_ff   <= rsp_flush_in;
      end
   end

   assign req_if.ready         = req_ready;
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.status        = rsp_status_ff;
   assign rsp_if.frame_result  = {rsp_frame_ff, FLAG_W'(0)};
   assign rsp_if.release_frame = rsp_release_ff;
   assign rsp_if.tlb_flush     = rsp_flush_ff;

`ifndef SYNTHESIS
   // claim count never passes the pool size
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      tbl_cnt_ff <= CNT_W'(NUM_TABLES))
      else $error("table claim count beyond pool size");

   // at most one table claimed per request
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (tbl_cnt_ff == $past(tbl_cnt_ff)) ||
                        (tbl_cnt_ff == $past(tbl_cnt_ff) + CNT_W'(1)))
      else $error("table claim count jumped");

   // a new result only comes out of a directory or table stage
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $rose(rsp_valid_ff) |->
         ($past(state_ff) == tlpt_pkg::S_DIR) || ($past(state_ff) == tlpt_pkg::S_TBL))
      else $error("result appeared outside a work stage");

   // no request taken during the clearing pass
   a_no_req_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tlpt_pkg::S_CLEAR) |=> !$past(req_beat))
      else $error("request accepted while clearing");
`endif

endmodule

`default_nettype wire
